>>> rtl/ctb_pkg.sv
package ctb_pkg;

  localparam int VALUE_W = 32;
  localparam int IDX_W   = 17;

  localparam int DEF_MAX_ITEMS = 65536;
  localparam int DEF_KEY_WIDTH = 32;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } ctb_state_t;

endpackage

>>> rtl/ctb_in_if.sv
interface ctb_in_if;
  import ctb_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;
  logic                      last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

>>> rtl/ctb_out_if.sv
interface ctb_out_if;
  import ctb_pkg::*;

  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] node_index;
  logic [IDX_W-1:0] left_child;
  logic [IDX_W-1:0] parent_index;
  logic             overflow;
  logic             end_of_sequence;

  modport source (output valid, output node_index, output left_child, output parent_index,
                  output overflow, output end_of_sequence, input ready);
  modport sink   (input valid, input node_index, input left_child, input parent_index,
                  input overflow, input end_of_sequence, output ready);
endinterface

>>> rtl/cartesian_tree_builder.sv
// Min-rooted Cartesian tree builder with a monotonic stack.
// Channels: items (value, last) in, results (node_index, left_child,
// parent_index, overflow, end_of_sequence) out, valid/ready on both.
// Each item gets the next node index from 1 and returns one result beat.
// An item is accepted in ST_IDLE, then pops its entries in ST_RUN. The
// stack sits in one synchronous memory; the top entry is held in registers
// and each pop reads the next one down, one memory read per cycle.
// The result beat is registered as the item leaves ST_RUN, after its pops.
// Over a sequence, pops average at most one per item.
// The result is registered; the next item is accepted while it waits.
// If the receiver stalls, the following item completes its pops and holds
// before pushing until the result register frees up.
// Items beyond MAX_ITEMS return overflow with zero indices and change nothing unless they carry last.
// A last beat clears the stack and the index counter after its item.
// Reset (rst, synchronous) empties the stack and clears the counter; the
// memory needs no clearing pass. No item is accepted while rst is high.
module cartesian_tree_builder #(
  parameter int MAX_ITEMS = ctb_pkg::DEF_MAX_ITEMS,
  parameter int KEY_WIDTH = ctb_pkg::DEF_KEY_WIDTH
) (
  input  logic      clk,
  input  logic      rst,
  ctb_in_if.sink    items,
  ctb_out_if.source results
);
  import ctb_pkg::*;

  localparam int AW  = $clog2(MAX_ITEMS);
  localparam int CW  = $clog2(MAX_ITEMS + 1);
  localparam int EW  = KEY_WIDTH + IDX_W;

  ctb_state_t state, state_next;

  logic [EW-1:0] mem [MAX_ITEMS];
  logic [EW-1:0] rd_data;

  logic [CW-1:0] sp;
  logic [CW-1:0] cnt;
  logic [CW-1:0] sp_m2;
  logic [CW-1:0] cnt_p1;
  logic          top_sel;

  logic signed [KEY_WIDTH-1:0] top_key_r;
  logic [IDX_W-1:0]            top_idx_r;
  logic signed [KEY_WIDTH-1:0] cur_key;
  logic                        cur_last;
  logic                        cur_ovf;
  logic [IDX_W-1:0]            left_r;

  logic signed [KEY_WIDTH-1:0] top_key;
  logic [IDX_W-1:0]            top_idx;
  logic [IDX_W-1:0]            new_idx;
  logic                        do_pop;
  logic                        out_free;
  logic                        finish;
  logic                        rd_en;
  logic                        wr_en;

  logic             res_valid;
  logic [IDX_W-1:0] res_node;
  logic [IDX_W-1:0] res_left;
  logic [IDX_W-1:0] res_parent;
  logic             res_ovf;
  logic             res_last;

  assign top_key  = top_sel ? $signed(rd_data[EW-1:IDX_W]) : top_key_r;
  assign top_idx  = top_sel ? rd_data[IDX_W-1:0] : top_idx_r;
  assign sp_m2    = sp - CW'(2);
  assign cnt_p1   = cnt + CW'(1);
  assign new_idx  = IDX_W'(cnt_p1);
  assign do_pop   = (state == ST_RUN) && !cur_ovf && (sp != '0) && (top_key > cur_key);
  assign out_free = !res_valid || results.ready;
  assign finish   = (state == ST_RUN) && !do_pop && out_free;
  assign rd_en    = do_pop && (sp > CW'(1));
  assign wr_en    = finish && !cur_ovf;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    items.ready = 1'b0;
    case (state)
      ST_IDLE: begin
        items.ready = !rst;
        if (items.valid) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (finish) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[sp[AW-1:0]] <= {cur_key, new_idx};
    end
    if (rd_en) begin
      rd_data <= mem[sp_m2[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sp        <= '0;
      cnt       <= '0;
      top_sel   <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (finish) begin
        res_valid <= 1'b1;
      end else if (results.ready) begin
        res_valid <= 1'b0;
      end
      if (state == ST_IDLE && items.valid) begin
        top_sel <= 1'b0;
      end
      if (do_pop) begin
        sp      <= sp - CW'(1);
        top_sel <= sp > CW'(1);
      end
      if (finish) begin
        top_sel <= 1'b0;
        if (cur_last) begin
          sp  <= '0;
          cnt <= '0;
        end else if (!cur_ovf) begin
          sp  <= sp + CW'(1);
          cnt <= cnt_p1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && items.valid) begin
      cur_key  <= KEY_WIDTH'(items.value);
      cur_last <= items.last;
      cur_ovf  <= cnt >= CW'(MAX_ITEMS);
      left_r   <= '0;
    end
    if (do_pop) begin
      left_r <= top_idx;
    end
    if (wr_en) begin
      top_key_r <= cur_key;
      top_idx_r <= new_idx;
    end
    if (finish) begin
      res_node   <= cur_ovf ? '0 : new_idx;
      res_left   <= cur_ovf ? '0 : left_r;
      res_parent <= (cur_ovf || sp == '0) ? '0 : top_idx;
      res_ovf    <= cur_ovf;
      res_last   <= cur_last;
    end
  end

  assign results.valid           = res_valid;
  assign results.node_index      = res_node;
  assign results.left_child      = res_left;
  assign results.parent_index    = res_parent;
  assign results.overflow        = res_ovf;
  assign results.end_of_sequence = res_last;

endmodule

>>> tb/cartesian_tree_builder_tb.sv
module cartesian_tree_builder_tb;
  import ctb_pkg::*;

  localparam int MAX_ITEMS   = DEF_MAX_ITEMS;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 20;
  localparam int PHASE_ITEMS = 363;

  typedef struct {
    logic [IDX_W-1:0] node;
    logic [IDX_W-1:0] left;
    logic [IDX_W-1:0] parent;
    logic             ovf;
    logic             eos;
  } tree_link_t;

  typedef enum int {
    PAT_RANDOM,
    PAT_NARROW,
    PAT_RAMP,
    PAT_EDGES,
    PAT_COUNT
  } key_pattern_t;

  logic clk;
  logic rst;

  ctb_in_if  item_bus ();
  ctb_out_if result_bus ();

  cartesian_tree_builder #(
    .MAX_ITEMS(MAX_ITEMS),
    .KEY_WIDTH(DEF_KEY_WIDTH)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .items  (item_bus),
    .results(result_bus)
  );

  logic signed [VALUE_W-1:0] stack_key [MAX_ITEMS];
  int                        stack_node [MAX_ITEMS];
  int                        stack_depth;
  int                        seq_count;

  tree_link_t pending_links [$];
  int         mismatches = 0;
  int         src_idle_pct;
  int         sink_stall_pct;
  logic       hold_results;
  int         ramp_key;
  event       hold_go;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic tree_link_t link_node(input logic signed [VALUE_W-1:0] v, input logic l);
    tree_link_t r;
    int         idx;
    r = '{default: '0};
    if (seq_count >= MAX_ITEMS) begin
      r.ovf = 1'b1;
    end else begin
      idx = seq_count + 1;
      while (stack_depth > 0 && stack_key[stack_depth-1] > v) begin
        stack_depth--;
        r.left = IDX_W'(stack_node[stack_depth]);
      end
      if (stack_depth > 0) r.parent = IDX_W'(stack_node[stack_depth-1]);
      stack_key[stack_depth]  = v;
      stack_node[stack_depth] = idx;
      stack_depth++;
      seq_count = idx;
      r.node    = IDX_W'(idx);
    end
    if (l) begin
      stack_depth = 0;
      seq_count   = 0;
    end
    r.eos = l;
    return r;
  endfunction

  task automatic send_item(input logic signed [VALUE_W-1:0] v, input logic l);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      item_bus.valid <= 1'b0;
      @(negedge clk);
    end
    item_bus.valid <= 1'b1;
    item_bus.value <= v;
    item_bus.last  <= l;
    do @(posedge clk); while (!item_bus.ready);
    pending_links.push_back(link_node(v, l));
  endtask

  task automatic stop_items();
    @(negedge clk);
    item_bus.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    stop_items();
    while (pending_links.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [VALUE_W-1:0] pick_key(input key_pattern_t pat);
    logic signed [VALUE_W-1:0] v;
    case (pat)
      PAT_RANDOM: v = $urandom();
      PAT_NARROW: v = int'($urandom_range(8)) - 4;
      PAT_RAMP: begin
        if ($urandom_range(15) == 0) ramp_key = ramp_key - int'($urandom_range(1000));
        else ramp_key = ramp_key + int'($urandom_range(3));
        v = ramp_key;
      end
      default: begin
        case ($urandom_range(4))
          0:       v = 32'sh8000_0000;
          1:       v = 32'sh7FFF_FFFF;
          2:       v = 0;
          3:       v = -1;
          default: v = $urandom();
        endcase
      end
    endcase
    return v;
  endfunction

  task automatic send_sequence(input key_pattern_t pat, input int len);
    ramp_key = $urandom();
    for (int i = 0; i < len; i++) send_item(pick_key(pat), i == len - 1);
  endtask

  task automatic check_field(input string name, input logic [IDX_W-1:0] want,
                             input logic [IDX_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    tree_link_t want;
    if (!rst && result_bus.valid && result_bus.ready) begin
      if (pending_links.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result beat, expected none, actual node %0d", $time,
                 result_bus.node_index);
      end else begin
        want = pending_links.pop_front();
        check_field("node_index", want.node, result_bus.node_index);
        check_field("left_child", want.left, result_bus.left_child);
        check_field("parent_index", want.parent, result_bus.parent_index);
        check_field("overflow", IDX_W'(want.ovf), IDX_W'(result_bus.overflow));
        check_field("end_of_sequence", IDX_W'(want.eos),
                    IDX_W'(result_bus.end_of_sequence));
      end
    end
  end

  always @(negedge clk) begin
    result_bus.ready <= !hold_results && ($urandom_range(99) >= sink_stall_pct);
  end

  initial begin
    hold_results = 1'b0;
    forever begin
      @(hold_go);
      hold_results = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_results = 1'b0;
    end
  end

  task automatic test_directed();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    send_item(5, 1'b0);
    send_item(3, 1'b0);
    send_item(3, 1'b0);
    send_item(8, 1'b0);
    send_item(32'sh7FFF_FFFF, 1'b0);
    send_item(32'sh8000_0000, 1'b0);
    send_item(32'sh8000_0000, 1'b0);
    send_item(7, 1'b0);
    send_item(0, 1'b0);
    send_item(-1, 1'b1);
    send_item(32'sh7FFF_FFFF, 1'b1);
    send_item(100, 1'b0);
    send_item(50, 1'b0);
    send_item(75, 1'b0);
    send_item(25, 1'b0);
    send_item(60, 1'b0);
    send_item(10, 1'b1);
    send_item(32'sh8000_0000, 1'b1);
    wait_drained();
  endtask

  task automatic test_random();
    int idle_mix [4][2];
    int sent;
    int len;
    idle_mix = '{'{0, 0}, '{58, 0}, '{0, 58}, '{33, 33}};
    for (int p = 0; p < 4; p++) begin
      src_idle_pct   = idle_mix[p][0];
      sink_stall_pct = idle_mix[p][1];
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(300, 60) : $urandom_range(40, 1);
        if (len > PHASE_ITEMS - sent) len = PHASE_ITEMS - sent;
        send_sequence(key_pattern_t'($urandom_range(PAT_COUNT - 1)), len);
        sent += len;
      end
      wait_drained();
    end
  endtask

  task automatic test_backpressure();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    -> hold_go;
    send_sequence(PAT_RANDOM, 80);
    wait_drained();
  endtask

  initial begin
    src_idle_pct     = 0;
    sink_stall_pct   = 0;
    rst              = 1'b1;
    item_bus.valid   = 1'b0;
    item_bus.value   = '0;
    item_bus.last    = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_random();
    test_backpressure();

    if (mismatches == 0 && pending_links.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

>>> sim.f
rtl/ctb_pkg.sv
rtl/ctb_in_if.sv
rtl/ctb_out_if.sv
rtl/cartesian_tree_builder.sv
tb/cartesian_tree_builder_tb.sv
